// File: src/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property that must hold on every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property violated");
// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: src/ldrf_pkg.sv
package ldrf_pkg;

  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int REG_W   = 5;
  localparam int VALUE_W = 32;

  // item operations
  localparam logic [OP_W-1:0] OP_STEP  = 2'd0;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // write kinds of a step
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd2;

  typedef logic [REG_W-1:0] reg_idx_t;

  // live value table entry: which bank holds the newest copy
  typedef enum logic [1:0] {
    LVT_ZERO,
    LVT_A,
    LVT_B
  } lvt_t;

  // where a read port takes its value from
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_BANK_A,
    SRC_BANK_B,
    SRC_BYP0,
    SRC_BYP1
  } src_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  write_kind;
    reg_idx_t           write_reg;
    logic [VALUE_W-1:0] write_value;
    reg_idx_t           read_reg_a;
    reg_idx_t           read_reg_b;
  } in_item_t;

  typedef struct packed {
    logic     en;
    reg_idx_t addr;
  } bank_wr_t;

  typedef struct packed {
    reg_idx_t idx_a;
    reg_idx_t idx_b;
    src_t     src_a;
    src_t     src_b;
  } rd_req_t;

endpackage

// File: src/ldrf_channels.sv
interface ldrf_instr_if;
  logic                             valid;
  logic                             ready;
  logic [ldrf_pkg::OP_W-1:0]        op;
  logic [ldrf_pkg::KIND_W-1:0]      write_kind;
  ldrf_pkg::reg_idx_t               write_reg;
  logic [ldrf_pkg::VALUE_W-1:0]     write_value;
  ldrf_pkg::reg_idx_t               read_reg_a;
  ldrf_pkg::reg_idx_t               read_reg_b;

  modport source (
    output valid, op, write_kind, write_reg, write_value, read_reg_a, read_reg_b,
    input  ready
  );
  modport sink (
    input  valid, op, write_kind, write_reg, write_value, read_reg_a, read_reg_b,
    output ready
  );
endinterface

interface ldrf_result_if;
  logic                         valid;
  logic                         ready;
  logic [ldrf_pkg::VALUE_W-1:0] read_data_a;
  logic [ldrf_pkg::VALUE_W-1:0] read_data_b;

  modport source (
    output valid, read_data_a, read_data_b,
    input  ready
  );
  modport sink (
    input  valid, read_data_a, read_data_b,
    output ready
  );
endinterface

// File: src/ldrf_bank.sv
module ldrf_bank #(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  ldrf_pkg::bank_wr_t        wr,
  input  logic [DATA_WIDTH-1:0]     wdata,
  input  logic                      rd_en,
  input  ldrf_pkg::reg_idx_t        raddr_a,
  input  ldrf_pkg::reg_idx_t        raddr_b,
  output logic [DATA_WIDTH-1:0]     rdata_a,
  output logic [DATA_WIDTH-1:0]     rdata_b
);

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [DATA_WIDTH-1:0] mem [REG_COUNT];

  // one write port, two registered read ports, read before write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[IDX_W'(wr.addr)] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[IDX_W'(raddr_a)];
      rdata_b <= mem[IDX_W'(raddr_b)];
    end
  end

endmodule

// File: src/ldrf_slots.sv
`include "assert_macros.svh"

module ldrf_slots #(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  ldrf_pkg::in_item_t        item,
  output ldrf_pkg::bank_wr_t        wr_a,
  output logic [DATA_WIDTH-1:0]     wdata_a,
  output ldrf_pkg::bank_wr_t        wr_b,
  output logic [DATA_WIDTH-1:0]     wdata_b,
  output logic [DATA_WIDTH-1:0]     byp0_value,
  output logic [DATA_WIDTH-1:0]     byp1_value,
  output ldrf_pkg::rd_req_t         rd
);

  import ldrf_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  logic                  slot_select;
  logic                  slot_select_next;
  reg_idx_t              pending_reg [2];
  reg_idx_t              pending_reg_next [2];
  logic [DATA_WIDTH-1:0] pending_value [2];
  logic [DATA_WIDTH-1:0] pending_value_next [2];
  lvt_t                  lvt [REG_COUNT];

  reg_idx_t              wr_idx;
  logic [DATA_WIDTH-1:0] wv;
  reg_idx_t              cur_reg;
  logic [DATA_WIDTH-1:0] cur_value;
  reg_idx_t              oth_reg;
  reg_idx_t              byp0_reg;
  reg_idx_t              byp1_reg;
  bank_wr_t              wr_a_raw;
  bank_wr_t              wr_b_raw;

  // indices beyond the file act as register zero
  function automatic reg_idx_t norm_idx(reg_idx_t raw);
    return (raw < REG_COUNT) ? raw : '0;
  endfunction

  function automatic src_t src_of(reg_idx_t r, reg_idx_t b0, reg_idx_t b1, lvt_t live);
    src_t s;
    s = SRC_ZERO;
    if (r == '0) begin
      s = SRC_ZERO;
    end else if (r == b1) begin
      s = SRC_BYP1;
    end else if (r == b0) begin
      s = SRC_BYP0;
    end else begin
      case (live)
        LVT_A:   s = SRC_BANK_A;
        LVT_B:   s = SRC_BANK_B;
        default: s = SRC_ZERO;
      endcase
    end
    return s;
  endfunction

  always_comb begin
    wr_idx    = norm_idx(item.write_reg);
    wv        = DATA_WIDTH'(item.write_value);
    cur_reg   = slot_select ? pending_reg[1] : pending_reg[0];
    cur_value = slot_select ? pending_value[1] : pending_value[0];
    oth_reg   = slot_select ? pending_reg[0] : pending_reg[1];

    wr_a_raw   = '0;
    wr_b_raw   = '0;
    wdata_a    = pending_value[0];
    wdata_b    = pending_value[1];
    byp0_reg   = '0;
    byp1_reg   = '0;
    byp0_value = pending_value[0];
    byp1_value = pending_value[1];

    slot_select_next      = slot_select;
    pending_reg_next[0]   = pending_reg[0];
    pending_reg_next[1]   = pending_reg[1];
    pending_value_next[0] = pending_value[0];
    pending_value_next[1] = pending_value[1];

    case (item.op)
      OP_STEP: begin
        // commit the current slot, then it becomes the other slot
        wr_a_raw.en   = (cur_reg != '0);
        wr_a_raw.addr = cur_reg;
        wdata_a       = cur_value;
        byp1_reg      = cur_reg;
        byp1_value    = cur_value;
        slot_select_next = ~slot_select;
        pending_reg_next[slot_select]   = '0;
        pending_value_next[slot_select] = '0;
        case (item.write_kind)
          KIND_LOAD: begin
            pending_reg_next[slot_select]   = wr_idx;
            pending_value_next[slot_select] = (wr_idx != '0) ? wv : '0;
            if (oth_reg == wr_idx) begin
              pending_reg_next[~slot_select]   = '0;
              pending_value_next[~slot_select] = '0;
            end
          end
          KIND_DIRECT: begin
            if (oth_reg == wr_idx) begin
              pending_reg_next[~slot_select]   = '0;
              pending_value_next[~slot_select] = '0;
            end
            wr_b_raw.en   = (wr_idx != '0);
            wr_b_raw.addr = wr_idx;
            wdata_b       = wv;
          end
          default: begin
          end
        endcase
      end
      OP_FLUSH: begin
        // slot 0 to bank a, slot 1 to bank b, so slot 1 wins a tie
        wr_a_raw.en   = (pending_reg[0] != '0);
        wr_a_raw.addr = pending_reg[0];
        wr_b_raw.en   = (pending_reg[1] != '0);
        wr_b_raw.addr = pending_reg[1];
        byp0_reg      = pending_reg[0];
        byp1_reg      = pending_reg[1];
        pending_reg_next[0]   = '0;
        pending_reg_next[1]   = '0;
        pending_value_next[0] = '0;
        pending_value_next[1] = '0;
      end
      OP_CLEAR: begin
        slot_select_next      = 1'b0;
        pending_reg_next[0]   = '0;
        pending_reg_next[1]   = '0;
        pending_value_next[0] = '0;
        pending_value_next[1] = '0;
      end
      default: begin
      end
    endcase

    wr_a.en   = wr_a_raw.en & accept;
    wr_a.addr = wr_a_raw.addr;
    wr_b.en   = wr_b_raw.en & accept;
    wr_b.addr = wr_b_raw.addr;

    rd.idx_a = norm_idx(item.read_reg_a);
    rd.idx_b = norm_idx(item.read_reg_b);
    rd.src_a = src_of(rd.idx_a, byp0_reg, byp1_reg, lvt[IDX_W'(rd.idx_a)]);
    rd.src_b = src_of(rd.idx_b, byp0_reg, byp1_reg, lvt[IDX_W'(rd.idx_b)]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_select    <= 1'b0;
      pending_reg[0] <= '0;
      pending_reg[1] <= '0;
    end else if (accept) begin
      slot_select    <= slot_select_next;
      pending_reg[0] <= pending_reg_next[0];
      pending_reg[1] <= pending_reg_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_value[0] <= pending_value_next[0];
      pending_value[1] <= pending_value_next[1];
    end
  end

  // bank b written after bank a so it wins on the same register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        lvt[i] <= LVT_ZERO;
      end
    end else begin
      if (wr_a.en) begin
        lvt[IDX_W'(wr_a.addr)] <= LVT_A;
      end
      if (wr_b.en) begin
        lvt[IDX_W'(wr_b.addr)] <= LVT_B;
      end
    end
  end

  `ASSERT_NEVER(a_bank_a_no_zero, clk, rst, wr_a.en && wr_a.addr == '0)
  `ASSERT_NEVER(a_bank_b_no_zero, clk, rst, wr_b.en && wr_b.addr == '0)
  `ASSERT_NEVER(a_no_twin_slots, clk, rst, pending_reg[0] != '0 && pending_reg[0] == pending_reg[1])
  `ASSERT_HOLDS(a_step_toggles, clk, rst, accept && item.op == OP_STEP |=> slot_select != $past(slot_select))
  `ASSERT_HOLDS(a_clear_empties, clk, rst, accept && item.op == OP_CLEAR |=> slot_select == 1'b0 && pending_reg[0] == '0 && pending_reg[1] == '0)

endmodule

// File: src/load_delay_register_file_unit.sv
// path: an accepted item is registered in stage 1, then in the result register
// throughput: one item per cycle; the input register stage only stalls while
//   the result register is full and not taken
// reset: rst is synchronous, active high; it empties both load slots, clears the
//   slot select and the live value table (every register reads as zero) and
//   drops any item in flight; no clearing pass, the block is ready at once
module load_delay_register_file_unit #(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input logic          clk,
  input logic          rst,
  ldrf_instr_if.sink   instr,
  ldrf_result_if.source result
);

  import ldrf_pkg::*;

  in_item_t              item;
  logic                  accept;
  logic                  s1_valid;
  logic                  s2_load;
  logic                  out_valid;

  bank_wr_t              wr_a;
  bank_wr_t              wr_b;
  logic [DATA_WIDTH-1:0] wdata_a;
  logic [DATA_WIDTH-1:0] wdata_b;
  logic [DATA_WIDTH-1:0] byp0_value;
  logic [DATA_WIDTH-1:0] byp1_value;
  rd_req_t               rd;

  // stage 1: read selects and commit bypass values, bank reads registered
  src_t                  src_a;
  src_t                  src_b;
  logic [DATA_WIDTH-1:0] byp0;
  logic [DATA_WIDTH-1:0] byp1;
  logic [DATA_WIDTH-1:0] a_rdata_a;
  logic [DATA_WIDTH-1:0] a_rdata_b;
  logic [DATA_WIDTH-1:0] b_rdata_a;
  logic [DATA_WIDTH-1:0] b_rdata_b;

  // stage 2: result register
  logic [VALUE_W-1:0]    out_data_a;
  logic [VALUE_W-1:0]    out_data_b;

  // the read value: bypass of this item's commit first, then the newest bank
  function automatic logic [DATA_WIDTH-1:0] pick(src_t src,
                                                  logic [DATA_WIDTH-1:0] bank_a,
                                                  logic [DATA_WIDTH-1:0] bank_b,
                                                  logic [DATA_WIDTH-1:0] p0,
                                                  logic [DATA_WIDTH-1:0] p1);
    logic [DATA_WIDTH-1:0] v;
    case (src)
      SRC_BANK_A: v = bank_a;
      SRC_BANK_B: v = bank_b;
      SRC_BYP0:   v = p0;
      SRC_BYP1:   v = p1;
      default:    v = '0;
    endcase
    return v;
  endfunction

  assign item = '{
    op:          instr.op,
    write_kind:  instr.write_kind,
    write_reg:   instr.write_reg,
    write_value: instr.write_value,
    read_reg_a:  instr.read_reg_a,
    read_reg_b:  instr.read_reg_b
  };

  // stage 1 moves on whenever the result register is free or being taken
  assign s2_load     = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || s2_load;
  assign accept      = instr.valid && instr.ready;

  // pending slots, slot select and live value table; all state moves on accept
  ldrf_slots #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_slots (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .wr_a       (wr_a),
    .wdata_a    (wdata_a),
    .wr_b       (wr_b),
    .wdata_b    (wdata_b),
    .byp0_value (byp0_value),
    .byp1_value (byp1_value),
    .rd         (rd)
  );

  // bank a takes slot commits, bank b direct writes and slot 1 of a flush
  ldrf_bank #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_bank_a (
    .clk     (clk),
    .wr      (wr_a),
    .wdata   (wdata_a),
    .rd_en   (accept),
    .raddr_a (rd.idx_a),
    .raddr_b (rd.idx_b),
    .rdata_a (a_rdata_a),
    .rdata_b (a_rdata_b)
  );

  ldrf_bank #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_bank_b (
    .clk     (clk),
    .wr      (wr_b),
    .wdata   (wdata_b),
    .rd_en   (accept),
    .raddr_a (rd.idx_a),
    .raddr_b (rd.idx_b),
    .rdata_a (b_rdata_a),
    .rdata_b (b_rdata_b)
  );

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      src_a <= rd.src_a;
      src_b <= rd.src_b;
      byp0  <= byp0_value;
      byp1  <= byp1_value;
    end
  end

  // result register, values cut or widened to the port width
  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data_a <= VALUE_W'(pick(src_a, a_rdata_a, b_rdata_a, byp0, byp1));
      out_data_b <= VALUE_W'(pick(src_b, a_rdata_b, b_rdata_b, byp0, byp1));
    end
  end

  assign result.valid       = out_valid;
  assign result.read_data_a = out_data_a;
  assign result.read_data_b = out_data_b;

endmodule

// File: sim/load_delay_register_file_unit_test.sv
module load_delay_register_file_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ldrf_pkg::*;

  // codes the package leaves unnamed: an op that does nothing, a write kind read as none
  localparam logic [OP_W-1:0]   OP_IDLE    = 2'd3;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int REG_COUNT   = 32;
  localparam int DIR_ROWS    = 25;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  // one result item: both read ports
  typedef struct packed {
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
  } read_pair_t;

  // directed row: the item, and the reads typed in where they are obvious
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KIND_W-1:0]  kind;
    reg_idx_t           wr;
    logic [VALUE_W-1:0] wv;
    reg_idx_t           ra;
    reg_idx_t           rb;
    logic               typed;
    logic [VALUE_W-1:0] xa;
    logic [VALUE_W-1:0] xb;
  } dir_row_t;

  logic clk;
  logic rst;

  ldrf_instr_if  instr_ch ();
  ldrf_result_if result_ch ();

  load_delay_register_file_unit #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (VALUE_W)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // shadow of the block: register file, the two load slots and the slot select
  logic [VALUE_W-1:0] gpr_shadow [REG_COUNT];
  reg_idx_t           slot_reg [2];
  logic [VALUE_W-1:0] slot_val [2];
  logic               cur_slot;

  // reads still owed by the block, oldest first
  read_pair_t due_reads [$];

  int fault_count = 0;
  int clk_ticks   = 0;

  // idling, in cycles of a hundred
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // long receiver hold-off, asked for by the stimulus and served by the receiver
  int hold_asked   = 0;
  int hold_granted = 0;
  int hold_left    = 0;

  // short directed walk; the first rows are typed in by hand
  dir_row_t dir_table [DIR_ROWS] = '{
    // straight after reset every register reads as zero
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd0,  5'd31, 1'b1, 32'h0, 32'h0},
    // direct write to the top register: reads come before the write
    '{OP_STEP,  KIND_DIRECT, 5'd31, 32'hFFFF_FFFF, 5'd31, 5'd0,  1'b1, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd31, 5'd0,  1'b1, 32'hFFFF_FFFF, 32'h0},
    // register zero drops a direct write
    '{OP_STEP,  KIND_DIRECT, 5'd0,  32'hFFFF_FFFF, 5'd0,  5'd0,  1'b1, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd0,  5'd31, 1'b1, 32'h0, 32'hFFFF_FFFF},
    // delayed load, then watch it land
    '{OP_STEP,  KIND_LOAD,   5'd1,  32'h1234_5678, 5'd1,  5'd1,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd1,  5'd31, 1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd1,  5'd0,  1'b0, 32'h0, 32'h0},
    // back-to-back loads to one register: the later one cancels the earlier
    '{OP_STEP,  KIND_LOAD,   5'd2,  32'hAAAA_AAAA, 5'd2,  5'd1,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_LOAD,   5'd2,  32'h5555_5555, 5'd2,  5'd1,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd2,  5'd1,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd2,  5'd0,  1'b0, 32'h0, 32'h0},
    // direct write cancels a load pending on the same register
    '{OP_STEP,  KIND_LOAD,   5'd3,  32'h0000_FFFF, 5'd3,  5'd2,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_DIRECT, 5'd3,  32'h1111_1111, 5'd3,  5'd2,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd3,  5'd2,  1'b0, 32'h0, 32'h0},
    // flush lands the pending load at once
    '{OP_STEP,  KIND_LOAD,   5'd4,  32'hDEAD_BEEF, 5'd4,  5'd3,  1'b0, 32'h0, 32'h0},
    '{OP_FLUSH, KIND_NONE,   5'd0,  32'h0000_0000, 5'd4,  5'd3,  1'b0, 32'h0, 32'h0},
    // clear throws the pending load away
    '{OP_STEP,  KIND_LOAD,   5'd5,  32'hCAFE_F00D, 5'd5,  5'd4,  1'b0, 32'h0, 32'h0},
    '{OP_CLEAR, KIND_NONE,   5'd0,  32'h0000_0000, 5'd5,  5'd4,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd5,  5'd1,  1'b0, 32'h0, 32'h0},
    // unused op and unused write kind change nothing
    '{OP_IDLE,  KIND_DIRECT, 5'd6,  32'h7777_7777, 5'd6,  5'd5,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_SPARE,  5'd7,  32'h8888_8888, 5'd7,  5'd6,  1'b0, 32'h0, 32'h0},
    // delayed load to register zero leaves its slot empty
    '{OP_STEP,  KIND_LOAD,   5'd0,  32'hFFFF_FFFF, 5'd0,  5'd7,  1'b0, 32'h0, 32'h0},
    '{OP_STEP,  KIND_NONE,   5'd0,  32'h0000_0000, 5'd31, 5'd2,  1'b0, 32'h0, 32'h0},
    '{OP_FLUSH, KIND_NONE,   5'd0,  32'h0000_0000, 5'd0,  5'd0,  1'b0, 32'h0, 32'h0}
  };

  // clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void drop_slot(logic s);
    slot_reg[s] = '0;
    slot_val[s] = '0;
  endfunction

  // a committed slot writes its register, never register zero
  function automatic void commit_slot(logic s);
    if (slot_reg[s] != '0) begin
      gpr_shadow[slot_reg[s]] = slot_val[s];
    end
    drop_slot(s);
  endfunction

  // apply one item to the shadow and return what the read ports show
  function automatic read_pair_t file_step(in_item_t it);
    read_pair_t rd;
    if (it.op == OP_STEP) begin
      commit_slot(cur_slot);
      cur_slot = ~cur_slot;
    end else if (it.op == OP_FLUSH) begin
      commit_slot(1'b0);
      commit_slot(1'b1);
    end else if (it.op == OP_CLEAR) begin
      drop_slot(1'b0);
      drop_slot(1'b1);
      cur_slot = 1'b0;
    end
    // register zero is never written, so it always reads zero
    rd.a = gpr_shadow[it.read_reg_a];
    rd.b = gpr_shadow[it.read_reg_b];
    if (it.op == OP_STEP) begin
      if (it.write_kind == KIND_LOAD) begin
        // the load waits in the slot that is not current
        slot_reg[~cur_slot] = it.write_reg;
        slot_val[~cur_slot] = (it.write_reg != '0) ? it.write_value : '0;
        if (slot_reg[cur_slot] == it.write_reg) begin
          drop_slot(cur_slot);
        end
      end else if (it.write_kind == KIND_DIRECT) begin
        if (slot_reg[cur_slot] == it.write_reg) begin
          drop_slot(cur_slot);
        end
        if (it.write_reg != '0) begin
          gpr_shadow[it.write_reg] = it.write_value;
        end
      end
    end
    return rd;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // register pick: mostly a handful of low registers so loads and writes collide
  function automatic reg_idx_t pick_reg();
    reg_idx_t r;
    if ($urandom_range(99) < 65) begin
      r = reg_idx_t'($urandom_range(7));
    end else begin
      r = reg_idx_t'($urandom_range(REG_COUNT - 1));
    end
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly instruction steps carrying loads and writes, with some flush, clear and noise
  function automatic in_item_t random_instr();
    in_item_t it;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 84) begin
      it.op = OP_STEP;
    end else if (roll < 91) begin
      it.op = OP_FLUSH;
    end else if (roll < 97) begin
      it.op = OP_CLEAR;
    end else begin
      it.op = OP_IDLE;
    end
    roll = $urandom_range(99);
    if (roll < 20) begin
      it.write_kind = KIND_NONE;
    end else if (roll < 60) begin
      it.write_kind = KIND_LOAD;
    end else if (roll < 96) begin
      it.write_kind = KIND_DIRECT;
    end else begin
      it.write_kind = KIND_SPARE;
    end
    it.write_reg   = pick_reg();
    it.write_value = pick_value();
    it.read_reg_a  = pick_reg();
    it.read_reg_b  = pick_reg();
    return it;
  endfunction

  // offer one item, wait for the handshake, then book its expected reads
  task automatic offer_instr(in_item_t it, logic typed, read_pair_t typed_rd);
    read_pair_t rd;
    // idle gap ahead of the item, valid low
    while ($urandom_range(99) < src_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid       <= 1'b1;
    instr_ch.op          <= it.op;
    instr_ch.write_kind  <= it.write_kind;
    instr_ch.write_reg   <= it.write_reg;
    instr_ch.write_value <= it.write_value;
    instr_ch.read_reg_a  <= it.read_reg_a;
    instr_ch.read_reg_b  <= it.read_reg_b;
    do @(posedge clk); while (!instr_ch.ready);
    rd = file_step(it);
    due_reads.push_back(typed ? typed_rd : rd);
  endtask

  task automatic random_phase(int n_items);
    read_pair_t unused;
    unused = '0;
    repeat (n_items) offer_instr(random_instr(), 1'b0, unused);
  endtask

  // ---------------------------------------------------------------- receiver

  // ready idles at random; a requested hold-off keeps it low for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (hold_granted != hold_asked) begin
        hold_granted = hold_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker

  // each accepted result against the oldest booked reads
  always @(posedge clk) begin
    read_pair_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (due_reads.size() == 0) begin
        $error("result item with nothing expected: a=%h b=%h",
               result_ch.read_data_a, result_ch.read_data_b);
        fault_count++;
      end else begin
        want = due_reads.pop_front();
        if (result_ch.read_data_a !== want.a) begin
          $error("read_data_a: expected %h, got %h", want.a, result_ch.read_data_a);
          fault_count++;
        end
        if (result_ch.read_data_b !== want.b) begin
          $error("read_data_b: expected %h, got %h", want.b, result_ch.read_data_b);
          fault_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    clk_ticks++;
    if (clk_ticks > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    in_item_t   it;
    read_pair_t typed_rd;

    // shadow after reset
    for (int i = 0; i < REG_COUNT; i++) gpr_shadow[i] = '0;
    drop_slot(1'b0);
    drop_slot(1'b1);
    cur_slot = 1'b0;

    // every input known from the start; the receiver drives its own ready
    rst                  <= 1'b1;
    instr_ch.valid       <= 1'b0;
    instr_ch.op          <= OP_STEP;
    instr_ch.write_kind  <= KIND_NONE;
    instr_ch.write_reg   <= '0;
    instr_ch.write_value <= '0;
    instr_ch.read_reg_a  <= '0;
    instr_ch.read_reg_b  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    src_idle_pct = 15;
    snk_idle_pct = 85;
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.op          = dir_table[i].op;
      it.write_kind  = dir_table[i].kind;
      it.write_reg   = dir_table[i].wr;
      it.write_value = dir_table[i].wv;
      it.read_reg_a  = dir_table[i].ra;
      it.read_reg_b  = dir_table[i].rb;
      typed_rd.a     = dir_table[i].xa;
      typed_rd.b     = dir_table[i].xb;
      offer_instr(it, dir_table[i].typed, typed_rd);
    end
    random_phase(200);

    // the other way round
    src_idle_pct = 85;
    snk_idle_pct = 15;
    random_phase(220);

    // no idling; a long hold-off lets the block fill and stall its input
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_asked   = hold_asked + 1;
    random_phase(230);
    instr_ch.valid <= 1'b0;

    // drain, then keep watching for anything stray
    while (due_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (due_reads.size() != 0) begin
      $error("%0d result items never arrived", due_reads.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: load_delay_register_file_unit.f
+incdir+src
src/ldrf_pkg.sv
src/ldrf_channels.sv
src/ldrf_bank.sv
src/ldrf_slots.sv
src/load_delay_register_file_unit.sv
sim/load_delay_register_file_unit_test.sv
